// File: sv/pkdhs_pkg.sv
// ----------------------------------------------------------------------------
// Pose key debounce package
// Shared widths, codes and types for the pose key debounce block.
// ----------------------------------------------------------------------------
package pkdhs_pkg;

  localparam int TIME_BITS    = 32;
  localparam int SCORE_BITS   = 16;
  localparam int CFG_BITS     = 20;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_DOWN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_UP   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_HOLD      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALLOW_EITHER  = 3'd3;

  typedef enum logic [1:0] {
    HAND_LEFT  = 2'd0,
    HAND_RIGHT = 2'd1,
    HAND_NONE  = 2'd2
  } hand_e;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_CAND_DOWN = 2'd1,
    ST_PRESSED   = 2'd2,
    ST_CAND_UP   = 2'd3
  } state_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_down_ticks;
    logic [CFG_BITS-1:0] debounce_up_ticks;
    logic [CFG_BITS-1:0] min_hold_ticks;
    logic                allow_either_hand;
  } cfg_t;

  // Candidate found by one hand lane.
  typedef struct packed {
    logic                  valid;
    logic                  pass;
    logic [SCORE_BITS-1:0] score;
  } cand_t;

  // Candidate chosen by the merge stage.
  typedef struct packed {
    hand_e                 hand;
    logic                  pass;
    logic [SCORE_BITS-1:0] score;
  } best_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  time_now;
    logic                  view_ok;
    logic                  left_tracked;
    logic                  left_passed;
    logic                  left_palm_ok;
    logic [SCORE_BITS-1:0] left_score;
    logic                  right_tracked;
    logic                  right_passed;
    logic                  right_palm_ok;
    logic [SCORE_BITS-1:0] right_score;
  } in_word_t;

  typedef struct packed {
    logic                  key_pressed;
    logic                  key_changed;
    logic [1:0]            binding_state;
    logic [1:0]            trigger_hand;
    logic [1:0]            best_hand;
    logic [SCORE_BITS-1:0] best_score;
    logic                  best_passed;
  } out_word_t;

endpackage

// File: sv/pkdhs_lane.sv
// ----------------------------------------------------------------------------
// Pose key hand lane
// Turns one hand's tracking, pass, palm and score results into a candidate.
// ----------------------------------------------------------------------------
module pkdhs_lane (
  input  logic                           tracked_i,
  input  logic                           passed_i,
  input  logic                           palm_ok_i,
  input  logic [pkdhs_pkg::SCORE_BITS-1:0] score_i,
  output pkdhs_pkg::cand_t               cand_o
);
  import pkdhs_pkg::*;

  logic usable;

  // A rejected palm keeps the hand valid but zeroes its pass and score.
  assign usable       = tracked_i & palm_ok_i;
  assign cand_o.valid = tracked_i;
  assign cand_o.pass  = usable & passed_i;
  assign cand_o.score = usable ? score_i : '0;

endmodule

// File: sv/pkdhs_merge.sv
// ----------------------------------------------------------------------------
// Pose key hand merge
// Picks the better of the two hand candidates.
// ----------------------------------------------------------------------------
module pkdhs_merge (
  input  logic             view_ok_i,
  input  logic             allow_either_i,
  input  pkdhs_pkg::hand_e holding_hand_i,
  input  pkdhs_pkg::cand_t left_i,
  input  pkdhs_pkg::cand_t right_i,
  output pkdhs_pkg::best_t best_o
);
  import pkdhs_pkg::*;

  logic right_wins;

  // The right hand wins over an invalid left, a lower left score, or an
  // exact tie while it already holds the key.
  assign right_wins = allow_either_i & right_i.valid &
                      (~left_i.valid | (right_i.score > left_i.score) |
                       ((right_i.score == left_i.score) &
                        (holding_hand_i == HAND_RIGHT)));

  always_comb begin
    best_o.hand  = HAND_NONE;
    best_o.pass  = 1'b0;
    best_o.score = '0;
    if (view_ok_i) begin
      if (right_wins) begin
        best_o.hand  = HAND_RIGHT;
        best_o.pass  = right_i.pass;
        best_o.score = right_i.score;
      end else if (left_i.valid) begin
        best_o.hand  = HAND_LEFT;
        best_o.pass  = left_i.pass;
        best_o.score = left_i.score;
      end
    end
  end

endmodule

// File: sv/pkdhs_fsm.sv
// ----------------------------------------------------------------------------
// Pose key debounce machine
// Idle, candidate down, pressed and candidate up states with press and
// release delays and a minimum hold time.
// ----------------------------------------------------------------------------
module pkdhs_fsm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            view_ok_i,
  input  logic [pkdhs_pkg::TIME_BITS-1:0] time_now_i,
  input  pkdhs_pkg::cfg_t                 cfg_i,
  input  pkdhs_pkg::best_t                best_i,
  output pkdhs_pkg::hand_e                holding_hand_o,
  output logic                            key_pressed_o,
  output logic                            key_changed_o,
  output pkdhs_pkg::state_e               state_o,
  output pkdhs_pkg::hand_e                trigger_hand_o
);
  import pkdhs_pkg::*;

  state_e               state_q, state_d;
  logic                 pressed_q, pressed_d;
  hand_e                hold_q, hold_d;
  logic [TIME_BITS-1:0] chg_q, chg_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] since_chg, since_start;
  logic                 down_done, up_done, hold_done;

  // Elapsed times wrap modulo the timestamp width.
  assign since_chg   = time_now_i - chg_q;
  assign since_start = time_now_i - start_q;
  assign down_done   = since_chg >= TIME_BITS'(cfg_i.debounce_down_ticks);
  assign up_done     = since_chg >= TIME_BITS'(cfg_i.debounce_up_ticks);
  assign hold_done   = since_start >= TIME_BITS'(cfg_i.min_hold_ticks);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pressed_q <= 1'b0;
      hold_q    <= HAND_NONE;
      chg_q     <= '0;
      start_q   <= '0;
    end else if (fire_i) begin
      state_q   <= state_d;
      pressed_q <= pressed_d;
      hold_q    <= hold_d;
      chg_q     <= chg_d;
      start_q   <= start_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pressed_d = pressed_q;
    hold_d    = hold_q;
    chg_d     = chg_q;
    start_d   = start_q;
    if (view_ok_i) begin
      case (state_q)
        ST_IDLE: begin
          if (best_i.pass) begin
            chg_d  = time_now_i;
            hold_d = best_i.hand;
            if (cfg_i.debounce_down_ticks != '0) begin
              state_d = ST_CAND_DOWN;
            end else begin
              state_d   = ST_PRESSED;
              pressed_d = 1'b1;
              start_d   = time_now_i;
            end
          end
        end
        ST_CAND_DOWN: begin
          if (!best_i.pass) begin
            state_d = ST_IDLE;
            hold_d  = HAND_NONE;
          end else if (down_done) begin
            state_d   = ST_PRESSED;
            pressed_d = 1'b1;
            start_d   = time_now_i;
          end
        end
        ST_PRESSED: begin
          if (!best_i.pass) begin
            chg_d = time_now_i;
            if ((cfg_i.debounce_up_ticks != '0) || (cfg_i.min_hold_ticks != '0)) begin
              state_d = ST_CAND_UP;
            end else begin
              state_d   = ST_IDLE;
              pressed_d = 1'b0;
              hold_d    = HAND_NONE;
            end
          end else begin
            hold_d = best_i.hand;
          end
        end
        ST_CAND_UP: begin
          if (best_i.pass) begin
            state_d = ST_PRESSED;
            hold_d  = best_i.hand;
          end else if (up_done && hold_done) begin
            state_d   = ST_IDLE;
            pressed_d = 1'b0;
            hold_d    = HAND_NONE;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  assign holding_hand_o = hold_q;
  assign key_pressed_o  = view_ok_i & pressed_d;
  assign key_changed_o  = view_ok_i & (pressed_d != pressed_q);
  assign state_o        = state_d;
  assign trigger_hand_o = hold_d;

endmodule

// File: sv/pose_key_debounce_with_hand_select.sv
// ----------------------------------------------------------------------------
// Pose key debounce with hand select
// One binding's pose key. Each input word is one camera frame: a timestamp,
// a view flag and both hands' tracked, pass, palm and score results. Two hand
// lanes form candidates, a merge stage picks the better hand, and a debounce
// machine turns the chosen pass into a key level with press and release
// delays and a minimum hold time. Every input word gives one output word.
// Both channels use valid and stall. An accepted word is registered in the
// output register; the block accepts a word every cycle while in_stall_o is
// low. The frame update (lane compares, merge and one state step) is
// combinational, and the state step is what the next frame depends on.
// When the receiver stalls, the output word holds and one more word lands in
// a skid register; in_stall_o then rises until the output drains.
// Configuration is a plain write port; the user writes it only while idle,
// as the block does not enforce it. Reset puts the machine in idle with no
// holding hand, zeroes all timing registers and empties the output side.
// ----------------------------------------------------------------------------
module pose_key_debounce_with_hand_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pkdhs_pkg::in_word_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pkdhs_pkg::out_word_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [pkdhs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pkdhs_pkg::CFG_BITS-1:0]     cfg_data_i
);
  import pkdhs_pkg::*;

  cfg_t      cfg_q;
  cand_t     left_cand, right_cand;
  best_t     best;
  hand_e     holding_hand;
  hand_e     trigger_hand;
  state_e    fsm_state;
  logic      key_pressed, key_changed;
  logic      in_fire, out_fire;
  out_word_t new_word;
  out_word_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_DOWN: cfg_q.debounce_down_ticks <= cfg_data_i;
        REG_DEBOUNCE_UP:   cfg_q.debounce_up_ticks   <= cfg_data_i;
        REG_MIN_HOLD:      cfg_q.min_hold_ticks      <= cfg_data_i;
        REG_ALLOW_EITHER:  cfg_q.allow_either_hand   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Two hand lanes work side by side.
  pkdhs_lane u_left (
    .tracked_i (in_data_i.left_tracked),
    .passed_i  (in_data_i.left_passed),
    .palm_ok_i (in_data_i.left_palm_ok),
    .score_i   (in_data_i.left_score),
    .cand_o    (left_cand)
  );

  pkdhs_lane u_right (
    .tracked_i (in_data_i.right_tracked),
    .passed_i  (in_data_i.right_passed),
    .palm_ok_i (in_data_i.right_palm_ok),
    .score_i   (in_data_i.right_score),
    .cand_o    (right_cand)
  );

  // The merge stage sees the hand that holds the key for tie breaking.
  pkdhs_merge u_merge (
    .view_ok_i      (in_data_i.view_ok),
    .allow_either_i (cfg_q.allow_either_hand),
    .holding_hand_i (holding_hand),
    .left_i         (left_cand),
    .right_i        (right_cand),
    .best_o         (best)
  );

  // The machine only advances on an accepted word.
  assign in_fire  = in_valid_i & ~skid_valid_q;
  assign out_fire = out_valid_q & ~out_stall_i;

  pkdhs_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .view_ok_i      (in_data_i.view_ok),
    .time_now_i     (in_data_i.time_now),
    .cfg_i          (cfg_q),
    .best_i         (best),
    .holding_hand_o (holding_hand),
    .key_pressed_o  (key_pressed),
    .key_changed_o  (key_changed),
    .state_o        (fsm_state),
    .trigger_hand_o (trigger_hand)
  );

  always_comb begin
    new_word.key_pressed   = key_pressed;
    new_word.key_changed   = key_changed;
    new_word.binding_state = fsm_state;
    new_word.trigger_hand  = trigger_hand;
    new_word.best_hand     = best.hand;
    new_word.best_score    = best.score;
    new_word.best_passed   = best.pass;
  end

  // Output register with a one-word skid behind it. The skid only fills when
  // a word arrives while the output word is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= new_word;
      end else begin
        out_q <= new_word;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/pkdhs_checker.sv
// ----------------------------------------------------------------------------
// Pose key debounce checker
// Port-level checks on the pose key block, bound to its top level.
// ----------------------------------------------------------------------------
module pkdhs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input pkdhs_pkg::out_word_t out_data_o
);
  import pkdhs_pkg::*;

  // A stalled output word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // The key is only down in the pressed or candidate up states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_pressed |->
      (out_data_o.binding_state == ST_PRESSED) ||
      (out_data_o.binding_state == ST_CAND_UP))
    else $error("key pressed outside a pressed state");

  // A change lands on a press into pressed or a release into idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_changed |->
      (out_data_o.key_pressed && (out_data_o.binding_state == ST_PRESSED)) ||
      (!out_data_o.key_pressed && (out_data_o.binding_state == ST_IDLE)))
    else $error("key change with inconsistent state");

  // Idle and only idle has no holding hand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.binding_state == ST_IDLE) == (out_data_o.trigger_hand == HAND_NONE))
    else $error("holding hand does not match state");

  // With no valid hand there is no score and no pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.best_hand == HAND_NONE) |->
      (out_data_o.best_score == '0) && !out_data_o.best_passed)
    else $error("empty candidate carries a score or pass");

endmodule

bind pose_key_debounce_with_hand_select pkdhs_checker u_pkdhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: test/pkdhs_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose key frame checker
// Watches both word channels and the register port of the pose key block,
// predicts the output word of every accepted frame and compares the words
// that leave the block against those predictions in order.
// ----------------------------------------------------------------------------
module pkdhs_frame_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  pkdhs_pkg::in_word_t                in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  pkdhs_pkg::out_word_t               out_data_i,
  input  logic                               cfg_we_i,
  input  logic [pkdhs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pkdhs_pkg::CFG_BITS-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import pkdhs_pkg::*;

  // Register copies.
  logic [CFG_BITS-1:0] down_ticks;
  logic [CFG_BITS-1:0] up_ticks;
  logic [CFG_BITS-1:0] hold_ticks;
  logic                allow_right;

  // Binding state.
  state_e               bind_state;
  logic                 key_down;
  hand_e                holder;
  logic [TIME_BITS-1:0] mark_time;
  logic [TIME_BITS-1:0] press_time;

  out_word_t key_words_q[$];
  int        words_checked;

  // Advances the binding by one frame and returns the word it should give.
  function automatic out_word_t step_frame(input in_word_t w);
    hand_e                 pick;
    logic                  pick_pass;
    logic [SCORE_BITS-1:0] pick_score;
    logic                  l_ok;
    logic                  r_ok;
    logic [SCORE_BITS-1:0] r_score;
    logic                  was_down;
    logic [TIME_BITS-1:0]  since_mark;
    logic [TIME_BITS-1:0]  since_press;
    out_word_t             o;
    pick        = HAND_NONE;
    pick_pass   = 1'b0;
    pick_score  = '0;
    was_down    = key_down;
    l_ok        = w.left_tracked & w.left_palm_ok;
    r_ok        = w.right_tracked & w.right_palm_ok;
    r_score     = r_ok ? w.right_score : '0;
    since_mark  = w.time_now - mark_time;
    since_press = w.time_now - press_time;
    if (w.view_ok) begin
      if (w.left_tracked) begin
        pick       = HAND_LEFT;
        pick_pass  = l_ok & w.left_passed;
        pick_score = l_ok ? w.left_score : '0;
      end
      if (allow_right && w.right_tracked && (pick == HAND_NONE || r_score > pick_score ||
          (r_score == pick_score && holder == HAND_RIGHT))) begin
        pick       = HAND_RIGHT;
        pick_pass  = r_ok & w.right_passed;
        pick_score = r_score;
      end
      case (bind_state)
        ST_IDLE: begin
          if (pick_pass) begin
            mark_time = w.time_now;
            holder    = pick;
            if (down_ticks != '0) begin
              bind_state = ST_CAND_DOWN;
            end else begin
              bind_state = ST_PRESSED;
              key_down   = 1'b1;
              press_time = w.time_now;
            end
          end
        end
        ST_CAND_DOWN: begin
          // The hand that opened the candidate keeps it, even if the pick moves.
          if (!pick_pass) begin
            bind_state = ST_IDLE;
            holder     = HAND_NONE;
          end else if (since_mark >= TIME_BITS'(down_ticks)) begin
            bind_state = ST_PRESSED;
            key_down   = 1'b1;
            press_time = w.time_now;
          end
        end
        ST_PRESSED: begin
          if (!pick_pass) begin
            mark_time = w.time_now;
            if (up_ticks != '0 || hold_ticks != '0) begin
              bind_state = ST_CAND_UP;
            end else begin
              bind_state = ST_IDLE;
              key_down   = 1'b0;
              holder     = HAND_NONE;
            end
          end else begin
            holder = pick;
          end
        end
        default: begin
          if (pick_pass) begin
            bind_state = ST_PRESSED;
            holder     = pick;
          end else if (since_mark >= TIME_BITS'(up_ticks) &&
                       since_press >= TIME_BITS'(hold_ticks)) begin
            bind_state = ST_IDLE;
            key_down   = 1'b0;
            holder     = HAND_NONE;
          end
        end
      endcase
    end
    o.key_pressed   = w.view_ok & key_down;
    o.key_changed   = w.view_ok & (was_down != key_down);
    o.binding_state = bind_state;
    o.trigger_hand  = holder;
    o.best_hand     = pick;
    o.best_score    = pick_score;
    o.best_passed   = pick_pass;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    logic      bad;
    if (!rst_ni) begin
      down_ticks    = '0;
      up_ticks      = '0;
      hold_ticks    = '0;
      allow_right   = 1'b0;
      bind_state    = ST_IDLE;
      key_down      = 1'b0;
      holder        = HAND_NONE;
      mark_time     = '0;
      press_time    = '0;
      words_checked = 0;
      fail_count_o  = 0;
      key_words_q.delete();
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_DOWN: down_ticks  = cfg_data_i;
          REG_DEBOUNCE_UP:   up_ticks    = cfg_data_i;
          REG_MIN_HOLD:      hold_ticks  = cfg_data_i;
          REG_ALLOW_EITHER:  allow_right = cfg_data_i[0];
          default: ;
        endcase
      end
      // Retire the oldest prediction before queuing this edge's frame.
      if (out_valid_i && !out_stall_i) begin
        if (key_words_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected output word %h", out_data_i);
          end
        end else begin
          want = key_words_q.pop_front();
          bad  = (want.key_pressed   !== out_data_i.key_pressed)   ||
                 (want.key_changed   !== out_data_i.key_changed)   ||
                 (want.binding_state !== out_data_i.binding_state) ||
                 (want.trigger_hand  !== out_data_i.trigger_hand)  ||
                 (want.best_hand     !== out_data_i.best_hand)     ||
                 (want.best_score    !== out_data_i.best_score)    ||
                 (want.best_passed   !== out_data_i.best_passed);
          if (bad) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("word %0d expected key=%0b chg=%0b st=%0d trig=%0d hand=%0d score=%0d pass=%0b",
                       words_checked, want.key_pressed, want.key_changed, want.binding_state,
                       want.trigger_hand, want.best_hand, want.best_score, want.best_passed);
              $display("word %0d actual   key=%0b chg=%0b st=%0d trig=%0d hand=%0d score=%0d pass=%0b",
                       words_checked, out_data_i.key_pressed, out_data_i.key_changed,
                       out_data_i.binding_state, out_data_i.trigger_hand,
                       out_data_i.best_hand, out_data_i.best_score, out_data_i.best_passed);
            end
          end
          words_checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        key_words_q.push_back(step_frame(in_data_i));
      end
      pending_o = key_words_q.size();
    end
  end

endmodule

// File: test/tb_pose_key_debounce_with_hand_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose key debounce testbench
// Drives camera frames into the pose key block through several register
// settings, with random gaps on both channels and one long output hold-off,
// while a checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_pose_key_debounce_with_hand_select;

  import pkdhs_pkg::*;

  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;

  // Length of the output hold-off that backs the block up into its input.
  localparam int SQUEEZE_CYCLES = 300;

  // All block inputs start at known values before the first clock edge.
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  in_word_t                in_data   = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx   = REG_DEBOUNCE_DOWN;
  logic [CFG_BITS-1:0]     cfg_data  = '0;

  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;
  int        fail_count;
  int        pending;

  // Idle percentages of the sender and the receiver; they change with the
  // number of words already sent.
  int src_gap = 0;
  int snk_gap = 0;

  // Long hold-off request from the stimulus and the hold itself.
  logic hold_req  = 1'b0;
  logic long_hold = 1'b0;

  // Stimulus state: pose runs for each hand, the running frame clock and
  // the largest step the clock takes between frames in the current phase.
  logic                 left_on  = 1'b0;
  logic                 right_on = 1'b0;
  logic [TIME_BITS-1:0] tick_now = '0;
  int                   step_max = 1;
  int                   words_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pose_key_debounce_with_hand_select u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  pkdhs_frame_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver stalls at random, and without a break while the long
  // hold-off is running.
  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < snk_gap);
  end

  // Once requested, the receiver holds off for a fixed stretch. The sender
  // keeps offering words meanwhile, so the output word and the skid register
  // fill and the block has to stall its input.
  initial begin
    while (!hold_req) @(posedge clk);
    long_hold <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Builds one frame from explicit field values.
  function automatic in_word_t mk(input logic [TIME_BITS-1:0] t, input logic view,
                                  input logic lt, input logic lp, input logic lpo,
                                  input logic [SCORE_BITS-1:0] ls,
                                  input logic rt, input logic rp, input logic rpo,
                                  input logic [SCORE_BITS-1:0] rs);
    in_word_t w;
    w.time_now      = t;
    w.view_ok       = view;
    w.left_tracked  = lt;
    w.left_passed   = lp;
    w.left_palm_ok  = lpo;
    w.left_score    = ls;
    w.right_tracked = rt;
    w.right_passed  = rp;
    w.right_palm_ok = rpo;
    w.right_score   = rs;
    return w;
  endfunction

  // Scores lean on the two ends of the range so that saturation and zero
  // both show up often.
  function automatic logic [SCORE_BITS-1:0] draw_score();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return SCORE_BITS'($urandom_range(65535));
  endfunction

  // Random frame. Each hand follows a pose that holds for runs of frames, so
  // most frames form press and release sequences; tracking losses, palm
  // rejects, view drops, flipped passes and clock jumps are the noise.
  function automatic in_word_t next_frame();
    in_word_t w;
    if ($urandom_range(99) < 15) begin
      left_on = !left_on;
    end
    if ($urandom_range(99) < 15) begin
      right_on = !right_on;
    end
    tick_now = tick_now + $urandom_range(step_max);
    if ($urandom_range(199) == 0) begin
      tick_now = $urandom();
    end
    w.time_now      = tick_now;
    w.view_ok       = $urandom_range(99) >= 6;
    w.left_tracked  = $urandom_range(99) >= 12;
    w.left_passed   = left_on ^ ($urandom_range(99) < 5);
    w.left_palm_ok  = $urandom_range(99) >= 10;
    w.left_score    = draw_score();
    w.right_tracked = $urandom_range(99) >= 12;
    w.right_passed  = right_on ^ ($urandom_range(99) < 5);
    w.right_palm_ok = $urandom_range(99) >= 10;
    // Exact ties between the hands exercise the holding-hand rule.
    w.right_score   = ($urandom_range(3) == 0) ? w.left_score : draw_score();
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken. The valid is
  // left high so the next word can follow without a gap.
  task automatic send_word(input in_word_t w);
    if (words_sent < 650) begin
      src_gap = 14;
      snk_gap = 78;
    end else if (words_sent < 1300) begin
      src_gap = 78;
      snk_gap = 14;
    end else begin
      src_gap = 0;
      snk_gap = 0;
    end
    while ($urandom_range(99) < src_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Waits until every predicted word has come back, then lets the clock run on
  // so nothing is still in flight. The count is read at the falling edge,
  // away from the checker's updates.
  task automatic settle();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_BITS-1:0] down, input logic [CFG_BITS-1:0] up,
                              input logic [CFG_BITS-1:0] hold, input logic either);
    write_reg(REG_DEBOUNCE_DOWN, down);
    write_reg(REG_DEBOUNCE_UP, up);
    write_reg(REG_MIN_HOLD, hold);
    write_reg(REG_ALLOW_EITHER, {{(CFG_BITS-1){1'b0}}, either});
    cfg_we <= 1'b0;
  endtask

  // One random phase under one register setting.
  task automatic run_phase(input logic [CFG_BITS-1:0] down, input logic [CFG_BITS-1:0] up,
                           input logic [CFG_BITS-1:0] hold, input logic either,
                           input int step, input int count, input logic squeeze);
    settle();
    program_regs(down, up, hold, either);
    tick_now = $urandom();
    step_max = step;
    if (squeeze) begin
      hold_req <= 1'b1;
    end
    repeat (count) send_word(next_frame());
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with a short press delay, a short release delay and a
    // hold time, both hands competing. Comments give the intended behavior.
    program_regs(20'd3, 20'd2, 20'd5, 1'b1);
    send_word(mk(32'd0, 1, 0, 0, 0, 16'd0, 0, 0, 0, 16'd0));          // no hand valid
    send_word(mk(32'd1, 1, 1, 1, 1, 16'hFFFF, 0, 1, 1, 16'd5));       // left opens a press
    send_word(mk(32'd2, 1, 1, 1, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF));    // tie stays with left
    send_word(mk(32'd4, 1, 1, 1, 1, 16'd100, 1, 1, 1, 16'd200));      // right wins, press
    send_word(mk(32'd5, 1, 1, 1, 1, 16'd200, 1, 0, 1, 16'd200));      // tie, left holds
    send_word(mk(32'd6, 0, 1, 1, 1, 16'd500, 1, 1, 1, 16'd600));      // view lost
    send_word(mk(32'd7, 1, 1, 1, 0, 16'hFFFF, 0, 0, 0, 16'd0));       // palm reject fails
    send_word(mk(32'd8, 1, 0, 0, 0, 16'd0, 0, 0, 0, 16'd0));          // release still waits
    send_word(mk(32'd9, 1, 0, 0, 0, 16'd0, 1, 1, 1, 16'd1));          // right takes over
    send_word(mk(32'd10, 1, 1, 1, 1, 16'd300, 1, 0, 1, 16'd300));     // tie to holding right
    send_word(mk(32'd12, 1, 1, 0, 1, 16'd0, 1, 0, 0, 16'hFFFF));      // delays done, release
    send_word(mk(32'hFFFF_FFFE, 1, 1, 1, 1, 16'd7, 0, 0, 0, 16'd0));  // press opens near wrap
    send_word(mk(32'h0000_0001, 1, 1, 1, 1, 16'd7, 0, 0, 0, 16'd0));  // press across the wrap
    send_word(mk(32'd2, 1, 1, 1, 1, 16'd7, 1, 1, 0, 16'd9));          // rejected right scores 0
    send_word(mk(32'd3, 1, 0, 0, 0, 16'd0, 0, 0, 0, 16'd0));          // release starts
    send_word(mk(32'hFFFF_FFF0, 1, 0, 0, 0, 16'd0, 0, 0, 0, 16'd0));  // clock jumps back
    in_valid <= 1'b0;

    // Left hand only; the upper data bits of the one-bit register are ignored.
    settle();
    write_reg(REG_ALLOW_EITHER, 20'hABCD0);
    cfg_we <= 1'b0;
    send_word(mk(32'd20, 1, 1, 0, 1, 16'd10, 1, 1, 1, 16'd60000));    // right never competes
    in_valid <= 1'b0;

    run_phase(20'd0, 20'd0, 20'd0, 1'b0, 3, 250, 1'b0);
    run_phase(20'd3, 20'd4, 20'd6, 1'b1, 3, 320, 1'b0);
    run_phase(20'd20, 20'd10, 20'd40, 1'b1, 8, 300, 1'b0);
    run_phase(20'd0, 20'd0, 20'd5, 1'b1, 2, 250, 1'b0);
    run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 700000, 150, 1'b0);
    run_phase(20'd5, 20'd0, 20'd0, 1'b1, 3, 300, 1'b0);

    // A write past the register list comes just before the last setting.
    settle();
    write_reg(REG_UNUSED, 20'hFFFFF);
    cfg_we <= 1'b0;
    run_phase(20'd2, 20'd7, 20'd0, 1'b0, 3, 364, 1'b1);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("pose_key_debounce_with_hand_select test passed");
    end else begin
      $display("pose_key_debounce_with_hand_select test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("pose_key_debounce_with_hand_select test failed");
    $finish;
  end

endmodule
